/* hdl/frtl_pkg.sv */
// Package for the reciprocal unit: widths, pipeline payload types and the
// two lookup tables, which are computed at elaboration. Depends on nothing.
`timescale 1ns / 1ps

package frtl_pkg;

   localparam int IndexBits = 10;
   localparam int LowBits   = 23 - IndexBits;
   localparam int RomDepth  = 1 << IndexBits;
   localparam logic [31:0] ExpBias2 = 32'd253;
   localparam real TwoPowM24 = 2.0 ** (-24);

   typedef logic [23:0] offset_rom_type [RomDepth];
   typedef logic [22:0] slope_rom_type  [RomDepth];

   typedef struct packed {
      logic        sign;
      logic [7:0]  exponent;
      logic [23:0] significand;
      logic [23:0] offset;
      logic [22:0] slope;
   } lookup_type;

   typedef struct packed {
      logic        sign;
      logic [7:0]  exponent;
      logic [23:0] offset;
      logic [23:0] product;
   } product_type;

   // Rounds a positive normal double to the nearest float, ties to even, and
   // returns the result as a double again.
   function automatic real round_to_float(input real value);
      logic [63:0] bits;
      logic [24:0] keep;
      logic [28:0] rest;
      logic [10:0] expo;
      bits = $realtobits(value);
      keep = {2'b01, bits[51:29]};
      rest = bits[28:0];
      expo = bits[62:52];
      if ((rest > 29'h1000_0000) || ((rest == 29'h1000_0000) && keep[0])) begin
         keep = keep + 25'd1;
      end
      if (keep[24]) begin
         keep = keep >> 1;
         expo = expo + 11'd1;
      end
      return $bitstoreal({1'b0, expo, keep[22:0], 29'd0});
   endfunction

   // Returns RomDepth / denom rounded to the nearest float, ties to even, for
   // denom from RomDepth to twice RomDepth. The quotient is formed by long
   // division with compare and subtract.
   function automatic real float_reciprocal(input int unsigned denom);
      logic [26:0] quot;
      logic [31:0] rem;
      logic [24:0] keep;
      quot = 27'd0;
      rem  = 32'(RomDepth);
      if (rem >= denom) begin
         quot = 27'd1;
         rem  = rem - denom;
      end
      for (int k = 0; k < 26; k++) begin
         rem  = rem << 1;
         quot = quot << 1;
         if (rem >= denom) begin
            quot[0] = 1'b1;
            rem     = rem - denom;
         end
      end
      if (quot[26]) begin
         return 1.0;
      end
      keep = {1'b0, quot[25:2]};
      if (quot[1] && (quot[0] || (rem != 32'd0) || keep[0])) begin
         keep = keep + 25'd1;
      end
      return real'(keep) * TwoPowM24;
   endfunction

   function automatic offset_rom_type build_offset_rom();
      offset_rom_type rom;
      real x1;
      real x2;
      real s;
      logic [63:0] cb;
      for (int i = 0; i < RomDepth; i++) begin
         x1 = float_reciprocal(unsigned'(RomDepth + i));
         x2 = float_reciprocal(unsigned'(RomDepth + i + 1));
         s = $sqrt(x1) + $sqrt(x2);
         cb = $realtobits(round_to_float((s * s) * 0.5));
         rom[i] = {1'b1, cb[51:29]};
      end
      return rom;
   endfunction

   function automatic slope_rom_type build_slope_rom();
      slope_rom_type rom;
      real x1;
      real x2;
      logic [63:0] gb;
      logic [23:0] gm;
      for (int i = 0; i < RomDepth; i++) begin
         x1 = float_reciprocal(unsigned'(RomDepth + i));
         x2 = float_reciprocal(unsigned'(RomDepth + i + 1));
         gb = $realtobits(round_to_float(x1 * x2));
         gm = {1'b1, gb[51:29]};
         if (gb[62:52] == 11'd1022) begin
            rom[i] = gm[23:1];
         end else begin
            rom[i] = {1'b0, gm[23:2]};
         end
      end
      return rom;
   endfunction

   localparam offset_rom_type OffsetRom = build_offset_rom();
   localparam slope_rom_type  SlopeRom  = build_slope_rom();

endpackage

/* hdl/float_reciprocal_table_linear.sv */
// Top level of the approximate float reciprocal: table lookup, multiply and
// final assembly stages. Depends on frtl_pkg, frtl_lookup and frtl_mul.
//
//   channel   ports                       transfer
//   request   start, busy, req_operand    start high while busy is low
//   result    rsp_valid, rsp_reciprocal   each cycle rsp_valid is high
//
// Every item passes through the registered stages in order: table read,
// multiply, subtract and assemble. busy stays low, so a new item may enter
// in every cycle. Reset clears the stage valid bits only.
`timescale 1ns / 1ps

module float_reciprocal_table_linear (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_operand,
   output logic        rsp_valid,
   output logic [31:0] rsp_reciprocal
);

   logic                  take;
   logic                  lookup_valid;
   frtl_pkg::lookup_type  lookup_data;
   logic                  product_valid;
   frtl_pkg::product_type product_data;
   logic [23:0]           difference;
   logic [31:0]           exponent_term;
   logic [31:0]           result_in;
   logic [31:0]           result_ff;
   logic                  valid_ff;

   assign busy = 1'b0;
   assign take = start && !busy;

   frtl_lookup u_lookup (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (take),
      .operand   (req_operand),
      .out_valid (lookup_valid),
      .out_data  (lookup_data)
   );

   frtl_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lookup_valid),
      .in_data   (lookup_data),
      .out_valid (product_valid),
      .out_data  (product_data)
   );

   always_comb begin
      difference    = product_data.offset - product_data.product;
      exponent_term = (frtl_pkg::ExpBias2 - {24'd0, product_data.exponent}) << 23;
      result_in     = {product_data.sign, 31'd0} + exponent_term
                    + {9'd0, difference[21:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= product_valid;
      end
      result_ff <= result_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_reciprocal = result_ff;

   // A request transfer yields a result after the lookup, multiply and output registers.
   assert property (@(posedge clock) disable iff (reset)
      $past(take, 3) && !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3)
      |-> rsp_valid)
      else $error("request transfer produced no result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(product_valid) && $past(lookup_valid, 2))
      else $error("result without an item in the earlier stages");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_reciprocal[0])
      else $error("result fraction LSB is set");

endmodule

/* hdl/frtl_lookup.sv */
// First stage: splits the operand and reads both tables into registers.
// Depends on frtl_pkg.
`timescale 1ns / 1ps

module frtl_lookup (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [31:0]            operand,
   output logic                   out_valid,
   output frtl_pkg::lookup_type   out_data
);

   logic                         valid_ff;
   frtl_pkg::lookup_type         data_ff;
   frtl_pkg::lookup_type         data_in;
   logic [frtl_pkg::IndexBits-1:0] index;

   always_comb begin
      index = operand[22:frtl_pkg::LowBits];
      data_in.sign        = operand[31];
      data_in.exponent    = operand[30:23];
      data_in.significand = {1'b1, operand[22:0]};
      data_in.offset      = frtl_pkg::OffsetRom[index];
      data_in.slope       = frtl_pkg::SlopeRom[index];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* hdl/frtl_mul.sv */
// Second stage: multiplies slope by significand and keeps the product
// scaled down by 2^23. Depends on frtl_pkg.
`timescale 1ns / 1ps

module frtl_mul (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  frtl_pkg::lookup_type   in_data,
   output logic                   out_valid,
   output frtl_pkg::product_type  out_data
);

   logic                         valid_ff;
   frtl_pkg::product_type        data_ff;
   frtl_pkg::product_type        data_in;
   logic [46:0]                  full_product;

   always_comb begin
      full_product     = 47'(in_data.slope) * 47'(in_data.significand);
      data_in.sign     = in_data.sign;
      data_in.exponent = in_data.exponent;
      data_in.offset   = in_data.offset;
      data_in.product  = full_product[46:23];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
